[rtl/core/jet_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types and constants for the jet colormap pixel block.
// ----------------------------------------------------------------------------
package jet_pkg;

	// default widths
	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 16;

	// reciprocal span register width and its binary point
	localparam int SCALE_BITS      = 27;
	localparam int SCALE_FRAC_BITS = 24;

	// register file
	localparam int REG_INDEX_BITS = 2;
	typedef logic [REG_INDEX_BITS-1:0] reg_index_t;
	localparam reg_index_t REG_LOW_LIMIT  = 2'd0;
	localparam reg_index_t REG_HIGH_LIMIT = 2'd1;
	localparam reg_index_t REG_SPAN_SCALE = 2'd2;

	// register reset values
	localparam int                    LOW_LIMIT_RESET  = 0;
	localparam int                    HIGH_LIMIT_RESET = 32767;
	localparam logic [SCALE_BITS-1:0] SPAN_SCALE_RESET = 27'd3072;

	// full intensity of one channel
	localparam logic [7:0] CHAN_FULL = 8'd255;

	// how a sample is colored
	typedef enum logic [1:0] {
		PIX_BLACK,
		PIX_WHITE,
		PIX_MAP
	} pix_class_t;

endpackage
`default_nettype wire

[rtl/core/jet_colormap_pixel.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jet_colormap_pixel
// Maps one signed sample to a jet-style RGB pixel through a fixed-point
// position, six color segments and linear channel ramps.
// ----------------------------------------------------------------------------
// Usage:
// The sample channel (in_valid, in_stall, sample) takes one sample per
// transfer; the pixel channel (out_valid, out_stall, red, green, blue) gives
// one pixel per transfer, in the order the samples came in.
// Software writes low_limit, high_limit and span_scale through the write port
// (wr_en, wr_index, wr_data) while no samples are in flight.
// A sample transfer loads the input register, then limit compare and
// subtract, span multiply, and segment select with ramps each fill one more
// register, the last one being the output register, which drives out_valid.
// One sample is taken every cycle unless in_stall is high; each stage moves
// whenever the stage after it is empty or moving.
// When the receiver stalls, the output register holds its pixel and the
// stages behind it keep filling until every stage is full; only then does
// in_stall rise.
// Reset empties the pipeline and loads low_limit = 0, high_limit = 32767 and
// span_scale = 3072.
// ----------------------------------------------------------------------------
module jet_colormap_pixel #(
	parameter int SAMPLE_BITS   = jet_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = jet_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              wr_en,
	input  wire jet_pkg::reg_index_t               wr_index,
	input  wire logic [((SAMPLE_BITS > jet_pkg::SCALE_BITS) ?
	                    SAMPLE_BITS : jet_pkg::SCALE_BITS)-1:0] wr_data,
	// sample channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample,
	// pixel channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [7:0]                             red,
	output logic [7:0]                             green,
	output logic [7:0]                             blue
);
	import jet_pkg::*;

	localparam int PROD_BITS = SAMPLE_BITS + SCALE_BITS;
	localparam int POS_SHIFT = SCALE_FRAC_BITS - FRACTION_BITS;
	localparam int POS_BITS  = FRACTION_BITS + 3;
	localparam logic [PROD_BITS-1:0] POS_MAX =
		(PROD_BITS'(6) << FRACTION_BITS) - PROD_BITS'(1);
	localparam logic [FRACTION_BITS:0] POS_ONE =
		(FRACTION_BITS+1)'(1) << FRACTION_BITS;

	// configuration registers
	logic signed [SAMPLE_BITS-1:0] low_limit_q;
	logic signed [SAMPLE_BITS-1:0] high_limit_q;
	logic [SCALE_BITS-1:0]         span_scale_q;

	// pipeline registers
	logic                          valid_s1, valid_s2, valid_s3;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	pix_class_t                    class_s2, class_s3;
	logic [SAMPLE_BITS-1:0]        diff_s2;
	logic [PROD_BITS-1:0]          prod_s3;

	// output register
	logic       out_valid_q;
	logic [7:0] red_q, green_q, blue_q;

	// stage enables
	logic en_out, en_s3, en_s2, en_s1;

	// stage 2 logic
	logic signed [SAMPLE_BITS:0] diff_full;
	pix_class_t                  class_d;

	// stage 3 logic
	logic [PROD_BITS-1:0]     pos_raw;
	logic [POS_BITS-1:0]      pos_sat;
	logic [2:0]               seg;
	logic [FRACTION_BITS-1:0] frac;
	logic [FRACTION_BITS+7:0] up_prod;
	logic [FRACTION_BITS:0]   down_x;
	logic [FRACTION_BITS+8:0] down_prod;
	logic [7:0]               ramp_up, ramp_down;
	logic [7:0]               red_d, green_d, blue_d;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q  <= SAMPLE_BITS'(LOW_LIMIT_RESET);
			high_limit_q <= SAMPLE_BITS'(HIGH_LIMIT_RESET);
			span_scale_q <= SPAN_SCALE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_LOW_LIMIT:  low_limit_q  <= wr_data[SAMPLE_BITS-1:0];
				REG_HIGH_LIMIT: high_limit_q <= wr_data[SAMPLE_BITS-1:0];
				REG_SPAN_SCALE: span_scale_q <= wr_data[SCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// stall chain: a stage moves when it is empty or the next one moves
	assign en_out   = !out_valid_q || !out_stall;
	assign en_s3    = !valid_s3 || en_out;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  valid_s1    <= in_valid;
			if (en_s2)  valid_s2    <= valid_s1;
			if (en_s3)  valid_s3    <= valid_s2;
			if (en_out) out_valid_q <= valid_s3;
		end
	end

	// limit compare and offset from the low limit
	always_comb begin
		diff_full = {sample_s1[SAMPLE_BITS-1], sample_s1} -
		            {low_limit_q[SAMPLE_BITS-1], low_limit_q};
		if (sample_s1 >= high_limit_q) begin
			class_d = PIX_BLACK;
		end else if (sample_s1 < low_limit_q) begin
			class_d = PIX_WHITE;
		end else begin
			class_d = PIX_MAP;
		end
	end

	// position, saturated just below six
	always_comb begin
		pos_raw = prod_s3 >> POS_SHIFT;
		if (pos_raw > POS_MAX) begin
			pos_sat = POS_MAX[POS_BITS-1:0];
		end else begin
			pos_sat = pos_raw[POS_BITS-1:0];
		end
		seg  = pos_sat[POS_BITS-1:FRACTION_BITS];
		frac = pos_sat[FRACTION_BITS-1:0];
	end

	// ramps: 255*x as (x << 8) - x, whole part kept
	always_comb begin
		up_prod   = {frac, 8'd0} - (FRACTION_BITS+8)'(frac);
		down_x    = POS_ONE - (FRACTION_BITS+1)'(frac);
		down_prod = {down_x, 8'd0} - (FRACTION_BITS+9)'(down_x);
		ramp_up   = up_prod[FRACTION_BITS+7:FRACTION_BITS];
		ramp_down = down_prod[FRACTION_BITS+7:FRACTION_BITS];
	end

	// segment select
	always_comb begin
		case (class_s3)
			PIX_BLACK: begin
				red_d = 8'd0; green_d = 8'd0; blue_d = 8'd0;
			end
			PIX_WHITE: begin
				red_d = CHAN_FULL; green_d = CHAN_FULL; blue_d = CHAN_FULL;
			end
			default: begin
				case (seg)
					3'd0: begin
						red_d = 8'd0; green_d = 8'd0; blue_d = ramp_up;
					end
					3'd1: begin
						red_d = 8'd0; green_d = ramp_up; blue_d = CHAN_FULL;
					end
					3'd2: begin
						red_d = ramp_up; green_d = CHAN_FULL; blue_d = ramp_down;
					end
					3'd3: begin
						red_d = CHAN_FULL; green_d = ramp_down; blue_d = 8'd0;
					end
					3'd4: begin
						red_d = CHAN_FULL; green_d = 8'd0; blue_d = 8'd0;
					end
					default: begin
						red_d = CHAN_FULL; green_d = ramp_up; blue_d = ramp_up;
					end
				endcase
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en_s1) begin
			sample_s1 <= sample;
		end
		if (en_s2) begin
			class_s2 <= class_d;
			diff_s2  <= diff_full[SAMPLE_BITS-1:0];
		end
		if (en_s3) begin
			class_s3 <= class_s2;
			prod_s3  <= PROD_BITS'(diff_s2) * PROD_BITS'(span_scale_q);
		end
		if (en_out) begin
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

`ifndef ASSERT_OFF
	// input stalls only when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && out_valid_q && out_stall))
		else $error("in_stall raised with room in the pipeline");

	// saturated position never selects past the last segment
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && class_s3 == PIX_MAP) |-> (seg <= 3'd5))
		else $error("segment index beyond five");

	// a sample at or above the high limit leaves as black
	a_black_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en_out && class_s3 == PIX_BLACK) |=>
		(out_valid && red == 8'd0 && green == 8'd0 && blue == 8'd0))
		else $error("black sample produced a colored pixel");
`endif

endmodule
`default_nettype wire
